>>> sv/swsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsc_pkg
// Shared types and constants of the sliding window sender control core.
// ----------------------------------------------------------------------------
package swsc_pkg;

	localparam int MAX_WINDOW_DEF = 64;
	localparam int RESULT_LIMIT   = 64;
	localparam int ACK_SAT        = 127;

	localparam logic [6:0]  RST_THRESH = 7'd16;
	localparam logic [6:0]  RST_WINDOW = 7'd1;
	localparam logic [31:0] RST_FIRST  = 32'd2;

	localparam logic [2:0] KIND_PUSH    = 3'd0;
	localparam logic [2:0] KIND_SEND    = 3'd1;
	localparam logic [2:0] KIND_ACK     = 3'd2;
	localparam logic [2:0] KIND_TIMEOUT = 3'd3;
	localparam logic [2:0] KIND_ENDR    = 3'd4;

	localparam logic [1:0] REG_THRESH = 2'd0;
	localparam logic [1:0] REG_WINDOW = 2'd1;
	localparam logic [1:0] REG_FIRST  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic load_item;
		logic emit_single;
		logic start_round;
		logic send_step;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       round_empty;
		logic       send_last;
	} status_t;

	typedef struct packed {
		logic        en;
		logic [1:0]  idx;
		logic [31:0] data;
	} cfg_wr_t;

endpackage

>>> sv/swsc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsc_ctrl
// Sequencer: takes one transaction, runs it in the datapath, steps send rounds.
// ----------------------------------------------------------------------------
module swsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  swsc_pkg::status_t status,
	output swsc_pkg::cmd_t    cmd
);

	swsc_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             slot_free;
	logic             single_kind;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		single_kind = status.kind inside {swsc_pkg::KIND_PUSH, swsc_pkg::KIND_ACK,
			swsc_pkg::KIND_TIMEOUT, swsc_pkg::KIND_ENDR};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			swsc_pkg::ST_IDLE: begin
				if (in_valid) state_d = swsc_pkg::ST_EXEC;
			end
			swsc_pkg::ST_EXEC: begin
				if (status.kind == swsc_pkg::KIND_SEND) begin
					state_d = status.round_empty ? swsc_pkg::ST_IDLE : swsc_pkg::ST_SEND;
				end else if (!single_kind || slot_free) begin
					state_d = swsc_pkg::ST_IDLE;
				end
			end
			swsc_pkg::ST_SEND: begin
				if (slot_free && status.send_last) state_d = swsc_pkg::ST_IDLE;
			end
			default: state_d = swsc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		cmd.load_item   = 1'b0;
		cmd.emit_single = 1'b0;
		cmd.start_round = 1'b0;
		cmd.send_step   = 1'b0;
		case (state_q)
			swsc_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			swsc_pkg::ST_EXEC: begin
				cmd.emit_single = single_kind && slot_free;
				cmd.start_round = status.kind == swsc_pkg::KIND_SEND;
			end
			swsc_pkg::ST_SEND: begin
				cmd.send_step = slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swsc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit_single || cmd.send_step) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> sv/swsc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsc_dpath
// Window, congestion state and result register of the sender control core.
// ----------------------------------------------------------------------------
module swsc_dpath #(
	parameter int MAX_WINDOW = swsc_pkg::MAX_WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  swsc_pkg::cmd_t    cmd,
	input  swsc_pkg::cfg_wr_t cfg_wr,
	input  logic [2:0]        kind,
	input  logic              is_fin,
	input  logic [31:0]       ack_number,
	output swsc_pkg::status_t status,
	output logic [31:0]       seq_number,
	output logic              accepted,
	output logic              is_resend,
	output logic              seg_fin,
	output logic [6:0]        popped,
	output logic              round_done,
	output logic              all_done,
	output logic [6:0]        window_now,
	output logic [6:0]        threshold_now,
	output logic              last
);

	localparam int CW  = $clog2(MAX_WINDOW + 1);
	localparam int CW1 = CW + 1;
	localparam int AW  = (CW > 7 ? CW : 7) + 1;
	localparam int SW  = AW - 1;
	localparam logic [CW-1:0] WMAX = CW'(MAX_WINDOW);
	localparam logic [CW-1:0] ONE  = CW'(1);

	logic [31:0]   base_q, base_d, next_q, next_d;
	logic [CW-1:0] count_q, count_d, sent_q, sent_d, cwnd_q, cwnd_d;
	logic [SW-1:0] ssth_q, ssth_d;
	logic [6:0]    acked_q, acked_d;
	logic          finq_q, finq_d, tout_q, tout_d, done_q, done_d;
	logic [CW-1:0] i_q, i_d, n_q, n_d;

	logic [2:0]    kind_q;
	logic          isfin_q;
	logic [31:0]   ack_q;

	logic [31:0]   seq_q, seq_d;
	logic          acc_q, acc_d, resend_q, resend_d, sfin_q, sfin_d;
	logic [6:0]    pop_q, pop_d;
	logic          rdone_q, rdone_d, last_q, last_d, adone_q, adone_d;
	logic [6:0]    win_q, win_d, thr_q, thr_d;
	logic          load_out;

	logic [CW-1:0] n_raw, n_calc, pop_w, half_w;
	logic [31:0]   diff;
	logic [AW-1:0] acked_sum;
	logic [CW:0]   grow_w;
	logic          room;
	logic [CW:0]   i_inc;

	always_comb begin
		n_raw = (count_q < cwnd_q) ? count_q : cwnd_q;
		if (AW'(n_raw) > AW'(swsc_pkg::RESULT_LIMIT)) n_calc = CW'(swsc_pkg::RESULT_LIMIT);
		else n_calc = n_raw;
	end

	assign i_inc              = CW1'(i_q) + CW1'(1);
	assign status.kind        = kind_q;
	assign status.round_empty = n_calc == '0;
	assign status.send_last   = i_inc == CW1'(n_q);

	always_comb begin
		base_d   = base_q;
		next_d   = next_q;
		count_d  = count_q;
		sent_d   = sent_q;
		cwnd_d   = cwnd_q;
		ssth_d   = ssth_q;
		acked_d  = acked_q;
		finq_d   = finq_q;
		tout_d   = tout_q;
		done_d   = done_q;
		i_d      = i_q;
		n_d      = n_q;
		load_out = 1'b0;
		seq_d    = '0;
		acc_d    = 1'b0;
		resend_d = 1'b0;
		sfin_d   = 1'b0;
		pop_d    = '0;
		rdone_d  = 1'b0;
		last_d   = 1'b0;
		room      = 1'b0;
		diff      = ack_q - base_q;
		pop_w     = '0;
		acked_sum = '0;
		half_w    = cwnd_q >> 1;
		grow_w    = '0;

		if (cfg_wr.en) begin
			case (cfg_wr.idx)
				swsc_pkg::REG_THRESH: begin
					ssth_d = (cfg_wr.data[6:0] == 7'd0) ? SW'(1) : SW'(cfg_wr.data[6:0]);
				end
				swsc_pkg::REG_WINDOW: begin
					if (cfg_wr.data[6:0] == 7'd0) cwnd_d = ONE;
					else if (AW'(cfg_wr.data[6:0]) > AW'(MAX_WINDOW)) cwnd_d = WMAX;
					else cwnd_d = CW'(cfg_wr.data[6:0]);
				end
				swsc_pkg::REG_FIRST: begin
					base_d  = cfg_wr.data;
					next_d  = cfg_wr.data;
					count_d = '0;
					sent_d  = '0;
				end
				default: ;
			endcase
		end

		if (cmd.emit_single) begin
			load_out = 1'b1;
			case (kind_q)
				swsc_pkg::KIND_PUSH: begin
					if (isfin_q) room = count_q < WMAX;
					else room = (count_q < cwnd_q) && (count_q < WMAX);
					if (room && !finq_q && !done_q) begin
						seq_d   = next_q;
						acc_d   = 1'b1;
						next_d  = next_q + 32'd1;
						count_d = count_q + ONE;
						if (isfin_q) finq_d = 1'b1;
					end
				end
				swsc_pkg::KIND_ACK: begin
					if (isfin_q) begin
						done_d = 1'b1;
						if (acked_q != 7'(swsc_pkg::ACK_SAT)) acked_d = acked_q + 7'd1;
					end else if (count_q != '0 && !diff[31]) begin
						pop_w     = (diff >= 32'(count_q)) ? count_q : CW'(diff) + ONE;
						base_d    = base_q + 32'(pop_w);
						count_d   = count_q - pop_w;
						sent_d    = (sent_q > pop_w) ? sent_q - pop_w : '0;
						acked_sum = AW'(acked_q) + AW'(pop_w);
						acked_d   = (acked_sum > AW'(swsc_pkg::ACK_SAT)) ?
							7'(swsc_pkg::ACK_SAT) : acked_sum[6:0];
					end
					pop_d   = 7'(pop_w);
					rdone_d = (AW'(acked_d) >= AW'(cwnd_q)) || (count_d == '0) || done_d;
				end
				swsc_pkg::KIND_TIMEOUT: begin
					ssth_d = (half_w == '0) ? SW'(1) : SW'(half_w);
					cwnd_d = ONE;
					tout_d = 1'b1;
				end
				swsc_pkg::KIND_ENDR: begin
					if (!tout_q) begin
						grow_w = (AW'(cwnd_q) < AW'(ssth_q)) ? {cwnd_q, 1'b0} :
							CW1'(cwnd_q) + CW1'(1);
						cwnd_d = (grow_w > CW1'(MAX_WINDOW)) ? WMAX : CW'(grow_w);
					end
					tout_d  = 1'b0;
					acked_d = '0;
				end
				default: ;
			endcase
		end

		if (cmd.start_round) begin
			acked_d = '0;
			tout_d  = 1'b0;
			i_d     = '0;
			n_d     = n_calc;
		end

		if (cmd.send_step) begin
			load_out = 1'b1;
			seq_d    = base_q + 32'(i_q);
			resend_d = i_q < sent_q;
			sfin_d   = finq_q && (i_inc == CW1'(count_q));
			last_d   = status.send_last;
			i_d      = CW'(i_inc);
			if (status.send_last && n_q > sent_q) sent_d = n_q;
		end

		adone_d = done_d;
		win_d   = 7'(cwnd_d);
		thr_d   = 7'(ssth_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= swsc_pkg::RST_FIRST;
			next_q  <= swsc_pkg::RST_FIRST;
			count_q <= '0;
			sent_q  <= '0;
			cwnd_q  <= CW'(swsc_pkg::RST_WINDOW);
			ssth_q  <= SW'(swsc_pkg::RST_THRESH);
			acked_q <= '0;
			finq_q  <= 1'b0;
			tout_q  <= 1'b0;
			done_q  <= 1'b0;
			i_q     <= '0;
			n_q     <= '0;
		end else begin
			base_q  <= base_d;
			next_q  <= next_d;
			count_q <= count_d;
			sent_q  <= sent_d;
			cwnd_q  <= cwnd_d;
			ssth_q  <= ssth_d;
			acked_q <= acked_d;
			finq_q  <= finq_d;
			tout_q  <= tout_d;
			done_q  <= done_d;
			i_q     <= i_d;
			n_q     <= n_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q  <= kind;
			isfin_q <= is_fin;
			ack_q   <= ack_number;
		end
		if (load_out) begin
			seq_q    <= seq_d;
			acc_q    <= acc_d;
			resend_q <= resend_d;
			sfin_q   <= sfin_d;
			pop_q    <= pop_d;
			rdone_q  <= rdone_d;
			adone_q  <= adone_d;
			win_q    <= win_d;
			thr_q    <= thr_d;
			last_q   <= last_d;
		end
	end

	assign seq_number    = seq_q;
	assign accepted      = acc_q;
	assign is_resend     = resend_q;
	assign seg_fin       = sfin_q;
	assign popped        = pop_q;
	assign round_done    = rdone_q;
	assign all_done      = adone_q;
	assign window_now    = win_q;
	assign threshold_now = thr_q;
	assign last          = last_q;

endmodule

>>> sv/sliding_window_sender_control_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_sender_control_core
// Go-back-N sender control with slow start and congestion avoidance.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) carries kind, is_fin, ack_number:
//    push, send round, ack, timeout, end of round. Kinds 5..7 are dropped.
//  - Output channel (out_valid/out_ready) carries one result per push, ack,
//    timeout and end of round, and one result per transmitted entry of a
//    send round, with last on the final one. An empty round gives nothing.
//  - A transaction is registered in the idle state, then executed in the
//    exec state. A send round gives one result per cycle through the output
//    register while the receiver does not stall it.
//  - in_ready is high only while the sequencer is idle; a result may still
//    sit in the output register then. A stalled receiver holds the output
//    register and the sequencer waits on it.
//  - APB registers: 0x0 initial_threshold, 0x4 initial_window,
//    0x8 first_sequence. Writes load the live state at once; write only
//    while idle. pready is tied high.
//  - Reset (arst_n low) loads the default register values and empties the
//    window; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sliding_window_sender_control_core #(
	parameter int MAX_WINDOW = swsc_pkg::MAX_WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic        is_fin,
	input  logic [31:0] ack_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] seq_number,
	output logic        accepted,
	output logic        is_resend,
	output logic        seg_fin,
	output logic [6:0]  popped,
	output logic        round_done,
	output logic        all_done,
	output logic [6:0]  window_now,
	output logic [6:0]  threshold_now,
	output logic        last
);

	logic [6:0]        thr_reg_q, win_reg_q;
	logic [31:0]       first_reg_q;
	swsc_pkg::cfg_wr_t cfg_wr;
	swsc_pkg::cmd_t    cmd;
	swsc_pkg::status_t status;

	assign pready      = 1'b1;
	assign cfg_wr.en   = psel && penable && pwrite && pready;
	assign cfg_wr.idx  = paddr[3:2];
	assign cfg_wr.data = pwdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_reg_q   <= swsc_pkg::RST_THRESH;
			win_reg_q   <= swsc_pkg::RST_WINDOW;
			first_reg_q <= swsc_pkg::RST_FIRST;
		end else if (cfg_wr.en) begin
			case (cfg_wr.idx)
				swsc_pkg::REG_THRESH: thr_reg_q   <= pwdata[6:0];
				swsc_pkg::REG_WINDOW: win_reg_q   <= pwdata[6:0];
				swsc_pkg::REG_FIRST:  first_reg_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			swsc_pkg::REG_THRESH: prdata = 32'(thr_reg_q);
			swsc_pkg::REG_WINDOW: prdata = 32'(win_reg_q);
			swsc_pkg::REG_FIRST:  prdata = first_reg_q;
			default:              prdata = '0;
		endcase
	end

	swsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	swsc_dpath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_wr        (cfg_wr),
		.kind          (kind),
		.is_fin        (is_fin),
		.ack_number    (ack_number),
		.status        (status),
		.seq_number    (seq_number),
		.accepted      (accepted),
		.is_resend     (is_resend),
		.seg_fin       (seg_fin),
		.popped        (popped),
		.round_done    (round_done),
		.all_done      (all_done),
		.window_now    (window_now),
		.threshold_now (threshold_now),
		.last          (last)
	);

endmodule

>>> tb/sliding_window_sender_control_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_sender_control_core_tb
// Self-checking bench for the go-back-N sender control core. Every accepted
// transaction is run through an in-bench window/congestion predictor. The
// predicted results are queued, and each result the core delivers is checked
// field by field against the oldest one. An opening table covers the reset
// state, the window growth rules, timeouts, stale and oversized acks and the
// ignored kinds. Random rounds follow under several register settings: push,
// send, acks, timeout and end of round, mixed with noise. A closing table
// covers a full 64-entry window, wrap of the sequence space and the fin
// segment. The fin closes the session for good, so it comes last.
// ----------------------------------------------------------------------------
module sliding_window_sender_control_core_tb;

	localparam int MAX_WIN        = swsc_pkg::MAX_WINDOW_DEF;
	localparam int N_SET          = 8;
	localparam int PHASE_ITEMS    = 30;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 5000;

	localparam logic [2:0] KIND_RSVD_LO = 3'd5;
	localparam logic [2:0] KIND_RSVD_HI = 3'd7;

	typedef struct packed {
		logic [31:0] seq;
		logic        acc;
		logic        resend;
		logic        fin;
		logic [6:0]  pop;
		logic        rdone;
		logic        alldone;
		logic [6:0]  win;
		logic [6:0]  thr;
		logic        last;
	} sw_result_t;

	typedef struct {
		logic [2:0]  kind;
		bit          fin;
		bit          rel;
		logic [31:0] ack;
		int          reps;
		bit          typed;
		sw_result_t  want;
	} stim_row_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        psel       = 1'b0;
	logic        penable    = 1'b0;
	logic        pwrite     = 1'b0;
	logic [3:0]  paddr      = '0;
	logic [31:0] pwdata     = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [2:0]  kind       = '0;
	logic        is_fin     = 1'b0;
	logic [31:0] ack_number = '0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [31:0] seq_number;
	logic        accepted;
	logic        is_resend;
	logic        seg_fin;
	logic [6:0]  popped;
	logic        round_done;
	logic        all_done;
	logic [6:0]  window_now;
	logic [6:0]  threshold_now;
	logic        last;

	// predictor state
	logic [31:0] sq_base, sq_next;
	int          n_entries, n_sent, cw, st, acked_rnd;
	bit          fin_q, fin_acked, timed_out;

	sw_result_t  due_results [$];
	stim_row_t   dir_rows [$];

	int fails           = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int tx_entries      = 0;
	int tx_resends      = 0;
	int burst_left      = 0;
	int quiet           = 0;
	int rx_span         = 0;
	int rx_mode         = 0;
	int rx_tick         = 0;

	sliding_window_sender_control_core #(
		.MAX_WINDOW(MAX_WIN)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.is_fin       (is_fin),
		.ack_number   (ack_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.seq_number   (seq_number),
		.accepted     (accepted),
		.is_resend    (is_resend),
		.seg_fin      (seg_fin),
		.popped       (popped),
		.round_done   (round_done),
		.all_done     (all_done),
		.window_now   (window_now),
		.threshold_now(threshold_now),
		.last         (last)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic sw_result_t mk(logic [31:0] s, bit acc, bit rs, bit fn, int pop,
			bit rd, bit lst);
		sw_result_t r;
		r.seq     = s;
		r.acc     = acc;
		r.resend  = rs;
		r.fin     = fn;
		r.pop     = 7'(pop);
		r.rdone   = rd;
		r.alldone = fin_acked;
		r.win     = 7'(cw);
		r.thr     = 7'(st);
		r.last    = lst;
		return r;
	endfunction

	function automatic sw_result_t fixed_result(logic [31:0] s, bit acc, int pop, bit rd,
			int win, int thr);
		sw_result_t r;
		r         = '0;
		r.seq     = s;
		r.acc     = acc;
		r.pop     = 7'(pop);
		r.rdone   = rd;
		r.win     = 7'(win);
		r.thr     = 7'(thr);
		return r;
	endfunction

	task automatic add_due(input sw_result_t r);
		due_results.insert(due_results.size(), r);
	endtask

	task automatic load_register(input logic [1:0] idx, input logic [31:0] val);
		int v;
		v = int'(val[6:0]);
		case (idx)
			swsc_pkg::REG_THRESH: begin
				st = (v < 1) ? 1 : v;
			end
			swsc_pkg::REG_WINDOW: begin
				cw = (v < 1) ? 1 : ((v > MAX_WIN) ? MAX_WIN : v);
			end
			swsc_pkg::REG_FIRST: begin
				sq_base   = val;
				sq_next   = val;
				n_entries = 0;
				n_sent    = 0;
			end
			default: ;
		endcase
	endtask

	task automatic advance_window(input logic [2:0] k, input bit f, input logic [31:0] a);
		int          n, pop, w;
		bit          room;
		logic [31:0] d;
		case (k)
			swsc_pkg::KIND_PUSH: begin
				room = f ? (n_entries < MAX_WIN) : (n_entries < cw && n_entries < MAX_WIN);
				if (room && !fin_q && !fin_acked) begin
					add_due(mk(sq_next, 1'b1, 1'b0, 1'b0, 0, 1'b0, 1'b0));
					sq_next = sq_next + 32'd1;
					n_entries++;
					if (f)
						fin_q = 1'b1;
				end else begin
					add_due(mk('0, 1'b0, 1'b0, 1'b0, 0, 1'b0, 1'b0));
				end
			end
			swsc_pkg::KIND_SEND: begin
				n = (n_entries < cw) ? n_entries : cw;
				if (n > swsc_pkg::RESULT_LIMIT)
					n = swsc_pkg::RESULT_LIMIT;
				acked_rnd = 0;
				timed_out = 1'b0;
				for (int i = 0; i < n; i++) begin
					add_due(mk(sq_base + 32'(i), 1'b0, i < n_sent,
						fin_q && (i + 1 == n_entries), 0, 1'b0, i + 1 == n));
					tx_entries++;
					if (i < n_sent)
						tx_resends++;
				end
				if (n > n_sent)
					n_sent = n;
			end
			swsc_pkg::KIND_ACK: begin
				pop = 0;
				if (f) begin
					fin_acked = 1'b1;
					if (acked_rnd < swsc_pkg::ACK_SAT)
						acked_rnd++;
				end else if (n_entries > 0) begin
					d = a - sq_base;
					if (!d[31]) begin
						pop       = (d >= 32'(n_entries)) ? n_entries : int'(d) + 1;
						sq_base   = sq_base + 32'(pop);
						n_entries = n_entries - pop;
						n_sent    = (n_sent > pop) ? n_sent - pop : 0;
						acked_rnd = acked_rnd + pop;
						if (acked_rnd > swsc_pkg::ACK_SAT)
							acked_rnd = swsc_pkg::ACK_SAT;
					end
				end
				add_due(mk('0, 1'b0, 1'b0, 1'b0, pop,
					acked_rnd >= cw || n_entries == 0 || fin_acked, 1'b0));
			end
			swsc_pkg::KIND_TIMEOUT: begin
				st        = (cw / 2 < 1) ? 1 : cw / 2;
				cw        = 1;
				timed_out = 1'b1;
				add_due(mk('0, 1'b0, 1'b0, 1'b0, 0, 1'b0, 1'b0));
			end
			swsc_pkg::KIND_ENDR: begin
				if (!timed_out) begin
					w  = (cw < st) ? cw * 2 : cw + 1;
					cw = (w > MAX_WIN) ? MAX_WIN : w;
				end
				timed_out = 1'b0;
				acked_rnd = 0;
				add_due(mk('0, 1'b0, 1'b0, 1'b0, 0, 1'b0, 1'b0));
			end
			default: ;
		endcase
	endtask

	task automatic flag_mismatch(input string what);
		fails++;
		$display("[%0t] MISMATCH %s", $time, what);
	endtask

	// sender: bursts of back-to-back transactions separated by random gaps
	task automatic issue(input logic [2:0] k, input bit f, input logic [31:0] a,
			input bit typed, input sw_result_t want);
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		burst_left--;
		kind       = k;
		is_fin     = f;
		ack_number = a;
		in_valid   = 1'b1;
		do @(posedge clk); while (!in_ready);
		advance_window(k, f, a);
		if (typed)
			due_results[due_results.size() - 1] = want;
		if (k <= swsc_pkg::KIND_ENDR)
			items_sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid   = 1'b0;
		burst_left = 0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		load_register(idx, val);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		if (prdata !== ((idx == swsc_pkg::REG_FIRST) ? val : {25'd0, val[6:0]}))
			flag_mismatch($sformatf("register %0d reads back %h", idx, prdata));
	endtask

	task automatic row(input logic [2:0] k, input bit f, input bit rel, input logic [31:0] a,
			input int reps, input bit typed, input sw_result_t want);
		stim_row_t r;
		r.kind  = k;
		r.fin   = f;
		r.rel   = rel;
		r.ack   = a;
		r.reps  = reps;
		r.typed = typed;
		r.want  = want;
		dir_rows.insert(dir_rows.size(), r);
	endtask

	task automatic run_rows();
		foreach (dir_rows[j]) begin
			repeat (dir_rows[j].reps)
				issue(dir_rows[j].kind, dir_rows[j].fin,
					dir_rows[j].rel ? sq_base + dir_rows[j].ack : dir_rows[j].ack,
					dir_rows[j].typed, dir_rows[j].want);
		end
		dir_rows.delete();
	endtask

	// receiver: stall pattern switches among four modes after a random span
	always @(negedge clk) begin
		if (rx_span == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_span = $urandom_range(16, 200);
		end
		rx_span--;
		rx_tick++;
		case (rx_mode)
			0: out_ready = 1'b1;
			1: out_ready = 1'($urandom_range(0, 1));
			2: out_ready = ($urandom_range(0, 3) == 0);
			default: out_ready = (rx_tick % 5) != 4;
		endcase
	end

	always @(posedge clk) begin : result_check
		sw_result_t got, exp;
		string      diff;
		if (arst_n && out_valid && out_ready) begin
			got.seq     = seq_number;
			got.acc     = accepted;
			got.resend  = is_resend;
			got.fin     = seg_fin;
			got.pop     = popped;
			got.rdone   = round_done;
			got.alldone = all_done;
			got.win     = window_now;
			got.thr     = threshold_now;
			got.last    = last;
			if (due_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result seq=%h", got.seq));
			end else begin
				exp = due_results[0];
				due_results.delete(0);
				results_checked++;
				diff = "";
				if (got.seq !== exp.seq)         diff = {diff, " seq_number"};
				if (got.acc !== exp.acc)         diff = {diff, " accepted"};
				if (got.resend !== exp.resend)   diff = {diff, " is_resend"};
				if (got.fin !== exp.fin)         diff = {diff, " seg_fin"};
				if (got.pop !== exp.pop)         diff = {diff, " popped"};
				if (got.rdone !== exp.rdone)     diff = {diff, " round_done"};
				if (got.alldone !== exp.alldone) diff = {diff, " all_done"};
				if (got.win !== exp.win)         diff = {diff, " window_now"};
				if (got.thr !== exp.thr)         diff = {diff, " threshold_now"};
				if (got.last !== exp.last)       diff = {diff, " last"};
				if (diff != "")
					flag_mismatch($sformatf("result %0d:%s exp=%h got=%h",
						results_checked, diff, exp, got));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			quiet = 0;
		else
			quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no transaction for %0d cycles, %0d results pending",
				$time, quiet, due_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [31:0] cfg_thr [N_SET];
		logic [31:0] cfg_win [N_SET];
		logic [31:0] cfg_first [N_SET];
		logic [31:0] a;
		logic [2:0]  nk;
		bit          nf;
		int          phase_start, k, m, r;

		sq_base   = swsc_pkg::RST_FIRST;
		sq_next   = swsc_pkg::RST_FIRST;
		n_entries = 0;
		n_sent    = 0;
		fin_q     = 1'b0;
		fin_acked = 1'b0;
		cw        = int'(swsc_pkg::RST_WINDOW);
		st        = int'(swsc_pkg::RST_THRESH);
		acked_rnd = 0;
		timed_out = 1'b0;

		cfg_thr[0] = 32'd16; cfg_win[0] = 32'd1;   cfg_first[0] = 32'd2;
		cfg_thr[1] = 32'd0;  cfg_win[1] = 32'd0;   cfg_first[1] = 32'd0;
		cfg_thr[2] = 32'd64; cfg_win[2] = 32'd64;  cfg_first[2] = 32'hFFFF_FFFF;
		cfg_thr[3] = 32'd1;  cfg_win[3] = 32'd64;  cfg_first[3] = 32'h7FFF_FFF0;
		cfg_thr[4] = 32'd64; cfg_win[4] = 32'd127; cfg_first[4] = 32'h8000_0000;
		cfg_thr[5] = 32'd8;  cfg_win[5] = 32'd3;   cfg_first[5] = $urandom;
		cfg_thr[6] = $urandom_range(1, 64);
		cfg_win[6] = $urandom_range(1, 64);
		cfg_first[6] = $urandom;
		cfg_thr[7] = $urandom_range(1, 64);
		cfg_win[7] = $urandom_range(1, 64);
		cfg_first[7] = 32'hFFFF_FFC0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// opening table, reset register values: window 1, threshold 16, first seq 2
		row(swsc_pkg::KIND_PUSH, 0, 0, '0, 1, 1, fixed_result(32'd2, 1, 0, 0, 1, 16));
		row(swsc_pkg::KIND_PUSH, 0, 0, '0, 1, 1, fixed_result('0, 0, 0, 0, 1, 16));
		row(swsc_pkg::KIND_SEND, 0, 0, '0, 2, 0, '0);
		row(swsc_pkg::KIND_ACK, 0, 1, 32'hFFFF_FFFF, 1, 1, fixed_result('0, 0, 0, 0, 1, 16));
		row(swsc_pkg::KIND_ACK, 0, 1, 32'd0, 1, 1, fixed_result('0, 0, 1, 1, 1, 16));
		row(swsc_pkg::KIND_ACK, 0, 1, 32'd5, 1, 0, '0);
		row(swsc_pkg::KIND_ENDR, 0, 0, '0, 1, 1, fixed_result('0, 0, 0, 0, 2, 16));
		row(swsc_pkg::KIND_ENDR, 0, 0, '0, 1, 1, fixed_result('0, 0, 0, 0, 4, 16));
		row(swsc_pkg::KIND_TIMEOUT, 0, 0, '0, 1, 1, fixed_result('0, 0, 0, 0, 1, 2));
		row(swsc_pkg::KIND_ENDR, 0, 0, '0, 1, 1, fixed_result('0, 0, 0, 0, 1, 2));
		row(swsc_pkg::KIND_ENDR, 0, 0, '0, 1, 1, fixed_result('0, 0, 0, 0, 2, 2));
		row(swsc_pkg::KIND_ENDR, 1, 0, '0, 1, 1, fixed_result('0, 0, 0, 0, 3, 2));
		row(KIND_RSVD_LO, 0, 0, '0, 1, 0, '0);
		row(KIND_RSVD_HI, 1, 0, 32'hFFFF_FFFF, 1, 0, '0);
		row(swsc_pkg::KIND_PUSH, 0, 0, 32'hFFFF_FFFF, 4, 0, '0);
		row(swsc_pkg::KIND_SEND, 1, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_ACK, 0, 1, 32'd1, 1, 0, '0);
		row(swsc_pkg::KIND_ACK, 0, 0, 32'h8000_0002, 1, 0, '0);
		row(swsc_pkg::KIND_ACK, 0, 0, 32'hFFFF_FFFF, 1, 0, '0);
		row(swsc_pkg::KIND_SEND, 0, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_ACK, 0, 1, 32'd1000, 1, 0, '0);
		row(swsc_pkg::KIND_SEND, 0, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_TIMEOUT, 1, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_ENDR, 0, 0, '0, 1, 0, '0);
		run_rows();

		for (int p = 0; p < N_SET; p++) begin
			settle();
			reg_write(swsc_pkg::REG_THRESH, cfg_thr[p]);
			reg_write(swsc_pkg::REG_WINDOW, cfg_win[p]);
			reg_write(swsc_pkg::REG_FIRST, cfg_first[p]);
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 78) begin
					// well-formed round: fill, transmit, ack, maybe time out, close
					k = $urandom_range(0, cw + 1);
					repeat (k) issue(swsc_pkg::KIND_PUSH, 1'b0, $urandom, 0, '0);
					if ($urandom_range(0, 9) != 0)
						issue(swsc_pkg::KIND_SEND, 1'($urandom_range(0, 1)), $urandom, 0, '0);
					if ($urandom_range(0, 4) == 0)
						issue(swsc_pkg::KIND_SEND, 1'b0, $urandom, 0, '0);
					m = $urandom_range(0, 4);
					repeat (m) begin
						r = $urandom_range(0, 99);
						if (r < 70)
							a = sq_base + $urandom_range(0, n_entries) - 32'd1;
						else if (r < 85)
							a = sq_base + $urandom_range(n_entries, n_entries + 5000);
						else
							a = $urandom;
						issue(swsc_pkg::KIND_ACK, 1'b0, a, 0, '0);
					end
					if ($urandom_range(0, 6) == 0)
						issue(swsc_pkg::KIND_TIMEOUT, 1'($urandom_range(0, 1)), $urandom,
							0, '0);
					if ($urandom_range(0, 9) != 0)
						issue(swsc_pkg::KIND_ENDR, 1'($urandom_range(0, 1)), $urandom, 0, '0);
				end else begin
					nk = 3'($urandom_range(0, 7));
					nf = (nk == swsc_pkg::KIND_PUSH || nk == swsc_pkg::KIND_ACK) ? 1'b0
						: 1'($urandom_range(0, 1));
					issue(nk, nf, $urandom, 0, '0);
				end
			end
		end

		// closing table: full window across the sequence wrap, then the fin
		settle();
		reg_write(swsc_pkg::REG_THRESH, 32'd8);
		reg_write(swsc_pkg::REG_WINDOW, 32'd64);
		reg_write(swsc_pkg::REG_FIRST, 32'hFFFF_FFF0);
		row(swsc_pkg::KIND_PUSH, 0, 0, '0, 64, 0, '0);
		row(swsc_pkg::KIND_PUSH, 0, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_PUSH, 1, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_SEND, 0, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_ACK, 0, 1, 32'd59, 1, 0, '0);
		row(swsc_pkg::KIND_TIMEOUT, 0, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_ENDR, 0, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_PUSH, 0, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_PUSH, 1, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_PUSH, 0, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_PUSH, 1, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_SEND, 0, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_ENDR, 0, 0, '0, 3, 0, '0);
		row(swsc_pkg::KIND_SEND, 0, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_ACK, 1, 0, 32'h1234_5678, 1, 0, '0);
		row(swsc_pkg::KIND_PUSH, 0, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_PUSH, 1, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_ACK, 0, 1, 32'd10, 1, 0, '0);
		row(swsc_pkg::KIND_ACK, 0, 1, 32'd0, 1, 0, '0);
		row(swsc_pkg::KIND_SEND, 0, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_TIMEOUT, 0, 0, '0, 1, 0, '0);
		row(swsc_pkg::KIND_ENDR, 0, 0, '0, 1, 0, '0);
		run_rows();

		settle();
		repeat (20) @(posedge clk);
		$display("Covered %0d transactions over %0d register settings plus opening and fin tables",
			items_sent, N_SET);
		$display("Checked %0d results: %0d transmitted entries, %0d of them resends",
			results_checked, tx_entries, tx_resends);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
